// ===== src/sra_pkg.sv =====
// ----------------------------------------------------------------------------
// sra_pkg : shared types and constants
// Item formats, table entry layout, sequencer states and the constant
// reciprocal used for the window mean.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sra_pkg;

   localparam int MAX_SENSORS = 64;
   localparam int WINDOW      = 8;

   localparam int IDX_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam int COUNT_W = $clog2(MAX_SENSORS + 1);
   localparam int WIN_LOG2 = $clog2(WINDOW);
   localparam int HEAD_W  = (WIN_LOG2 > 0) ? WIN_LOG2 : 1;
   localparam int WIN_DEPTH = MAX_SENSORS * WINDOW;
   localparam int WADDR_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

   // running sum of WINDOW signed 16-bit samples
   localparam int SUM_W = 16 + WIN_LOG2;

   // mean = floor((sum + BIAS) / WINDOW) - 2^15, biased value is never negative
   localparam int      BIAS_W     = 16 + WIN_LOG2;
   localparam longint  BIAS       = longint'(WINDOW) * 32768;
   localparam int      DIV_SHIFT  = BIAS_W + WIN_LOG2;
   localparam longint  RECIP      = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
   localparam int      RECIP_W    = BIAS_W + 1;
   localparam int      PROD_W     = BIAS_W + RECIP_W;

   localparam logic [1:0]  CMD_REGISTER   = 2'd0;
   localparam logic [1:0]  CMD_SAMPLE     = 2'd1;
   localparam logic [15:0] NOT_FOUND_ROOM = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_UNKNOWN    = 2'd1,
      ST_FULL       = 2'd2,
      ST_REGISTERED = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [15:0]        sensor_key;
      logic [15:0]        room;
      logic signed [15:0] temperature;
      logic [31:0]        timestamp;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [15:0]        room_of_sensor;
      logic signed [15:0] average;
      logic [31:0]        last_update;
      logic [6:0]         sensor_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0]              id;
      logic [15:0]              room;
      logic [31:0]              last_time;
      logic signed [15:0]       average;
      logic signed [SUM_W-1:0]  sum;
      logic [HEAD_W-1:0]        head;
      logic                     full;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } ent_wr_type;

   typedef struct packed {
      logic             re;
      logic [IDX_W-1:0] addr;
   } ent_rd_type;

   typedef struct packed {
      logic               we;
      logic [WADDR_W-1:0] addr;
      logic signed [15:0] data;
   } win_wr_type;

   typedef struct packed {
      logic               re;
      logic [WADDR_W-1:0] addr;
   } win_rd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REG,
      S_SCAN,
      S_WIN,
      S_MUL,
      S_WB,
      S_RESP
   } state_type;

   function automatic logic [WADDR_W-1:0] win_addr(logic [IDX_W-1:0] e,
                                                   logic [HEAD_W-1:0] h);
      return WADDR_W'(WADDR_W'(e) * WINDOW + WADDR_W'(h));
   endfunction

endpackage

`default_nettype wire

// ===== src/sra_ram.sv =====
// ----------------------------------------------------------------------------
// sra_ram : simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sra_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output      logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/sra_ctrl.sv =====
// ----------------------------------------------------------------------------
// sra_ctrl : command sequencer and datapath
// Registers new entries, scans the entry RAM for the first matching id, updates
// the window and running sum for samples, forms the floor mean and holds the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sra_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire sra_pkg::req_type    req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      sra_pkg::rsp_type    rsp_data,
   output      sra_pkg::ent_wr_type ent_wr,
   output      sra_pkg::ent_rd_type ent_rd,
   input  wire sra_pkg::entry_type  ent_rdata,
   output      sra_pkg::win_wr_type win_wr,
   output      sra_pkg::win_rd_type win_rd,
   input  wire logic signed [15:0]  win_rdata
);

   import sra_pkg::*;

   state_type               state_ff, state_in;
   req_type                 item_ff, item_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]        scan_ff, scan_in;
   entry_type               entry_ff, entry_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   rsp_type                 res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    id_match;
   logic                    scan_last;
   logic                    last_slot;
   logic [BIAS_W-1:0]       biased;
   logic signed [15:0]      avg_new;
   rsp_type                 res_unknown;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      scan_ff     <= scan_in;
      entry_ff    <= entry_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign id_match  = (ent_rdata.id == item_ff.sensor_key);
   assign scan_last = ((COUNT_W'(scan_ff) + COUNT_W'(1)) == count_ff);
   assign last_slot = (entry_ff.head == HEAD_W'(WINDOW - 1));
   assign biased    = BIAS_W'(sum_ff) + BIAS_W'(BIAS);
   // top bit flip removes the 2^15 bias
   assign avg_new   = prod_ff[DIV_SHIFT +: 16] ^ 16'h8000;

   always_comb begin
      res_unknown.status         = ST_UNKNOWN;
      res_unknown.room_of_sensor = NOT_FOUND_ROOM;
      res_unknown.average        = '0;
      res_unknown.last_update    = '0;
      res_unknown.sensor_count   = 7'(count_ff);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      entry_in     = entry_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_stall    = 1'b1;
      ent_wr       = '0;
      ent_rd       = '0;
      win_wr       = '0;
      win_rd       = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               item_in = req_data;
               if (req_data.cmd == CMD_REGISTER) begin
                  state_in = S_REG;
               end else if (count_ff == '0) begin
                  res_in   = res_unknown;
                  state_in = S_RESP;
               end else begin
                  ent_rd.re   = 1'b1;
                  ent_rd.addr = '0;
                  scan_in     = '0;
                  state_in    = S_SCAN;
               end
            end
         end

         S_REG: begin
            if (count_ff == COUNT_W'(MAX_SENSORS)) begin
               res_in        = res_unknown;
               res_in.status = ST_FULL;
            end else begin
               ent_wr.we             = 1'b1;
               ent_wr.addr           = IDX_W'(count_ff);
               ent_wr.data           = '0;
               ent_wr.data.id        = item_ff.sensor_key;
               ent_wr.data.room      = item_ff.room;
               count_in              = count_ff + COUNT_W'(1);
               res_in.status         = ST_REGISTERED;
               res_in.room_of_sensor = item_ff.room;
               res_in.average        = '0;
               res_in.last_update    = '0;
               res_in.sensor_count   = 7'(count_ff + COUNT_W'(1));
            end
            state_in = S_RESP;
         end

         S_SCAN: begin
            // read data belongs to entry scan_ff
            if (id_match) begin
               entry_in = ent_rdata;
               if (item_ff.cmd == CMD_SAMPLE) begin
                  win_rd.re   = 1'b1;
                  win_rd.addr = win_addr(scan_ff, ent_rdata.head);
                  state_in    = S_WIN;
               end else begin
                  res_in.status         = ST_DONE;
                  res_in.room_of_sensor = ent_rdata.room;
                  res_in.average        = ent_rdata.average;
                  res_in.last_update    = ent_rdata.last_time;
                  res_in.sensor_count   = 7'(count_ff);
                  state_in              = S_RESP;
               end
            end else if (scan_last) begin
               res_in   = res_unknown;
               state_in = S_RESP;
            end else begin
               scan_in     = scan_ff + IDX_W'(1);
               ent_rd.re   = 1'b1;
               ent_rd.addr = scan_ff + IDX_W'(1);
            end
         end

         S_WIN: begin
            // oldest slot counts as zero until the window has wrapped once
            sum_in = entry_ff.sum
                   - (entry_ff.full ? SUM_W'(win_rdata) : SUM_W'(0))
                   + SUM_W'(item_ff.temperature);
            win_wr.we   = 1'b1;
            win_wr.addr = win_addr(scan_ff, entry_ff.head);
            win_wr.data = item_ff.temperature;
            state_in    = S_MUL;
         end

         S_MUL: begin
            prod_in  = PROD_W'(biased) * PROD_W'(RECIP);
            state_in = S_WB;
         end

         S_WB: begin
            ent_wr.we             = 1'b1;
            ent_wr.addr           = scan_ff;
            ent_wr.data           = entry_ff;
            ent_wr.data.sum       = sum_ff;
            ent_wr.data.average   = avg_new;
            ent_wr.data.last_time = item_ff.timestamp;
            ent_wr.data.head      = last_slot ? '0 : entry_ff.head + HEAD_W'(1);
            ent_wr.data.full      = entry_ff.full | last_slot;
            res_in.status         = ST_DONE;
            res_in.room_of_sensor = entry_ff.room;
            res_in.average        = avg_new;
            res_in.last_update    = item_ff.timestamp;
            res_in.sensor_count   = 7'(count_ff);
            state_in              = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/sensor_running_average_table.sv =====
// One item at a time: a new item is taken only in the idle state, after the
// previous one has moved to the output register. Lookups scan the ids serially
// through the entry RAM read port.
// Reset clears the entry count, sequencer and output valid; no RAM clearing
// pass, as entries at or above the count are never read.
// ----------------------------------------------------------------------------
// sensor_running_average_table : per-id moving average table
// Entries live in an entry RAM (id, room, time, mean, running sum, window
// pointer) and a window RAM of WINDOW samples per entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sensor_running_average_table (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire sra_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      sra_pkg::rsp_type rsp_data
);

   import sra_pkg::*;

   // Flow of one sample item (a registration goes through REG, a query from SCAN to RESP):
   //   IDLE  - item taken; a lookup issues a read of entry 0
   //   SCAN  - one entry compared per cycle, first match wins
   //   WIN   - oldest window sample arrives; new sample written in its slot,
   //           running sum updated (oldest counts as zero until the window
   //           has filled, so registration need not clear the window RAM)
   //   MUL   - floor mean via constant reciprocal on the biased sum
   //   WB    - entry written back
   //   RESP  - item moved to the output register once it is free
   // Each item finishes all its RAM writes before the next is taken, so no
   // read of one item can see a stale entry from the previous one.

   ent_wr_type         ent_wr;
   ent_rd_type         ent_rd;
   entry_type          ent_rdata;
   win_wr_type         win_wr;
   win_rd_type         win_rd;
   logic signed [15:0] win_rdata;

   sra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .ent_wr    (ent_wr),
      .ent_rd    (ent_rd),
      .ent_rdata (ent_rdata),
      .win_wr    (win_wr),
      .win_rd    (win_rd),
      .win_rdata (win_rdata)
   );

   // entry records, one per registered sensor
   sra_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_SENSORS)
   ) u_ent_ram (
      .clock (clock),
      .we    (ent_wr.we),
      .waddr (ent_wr.addr),
      .wdata (ent_wr.data),
      .re    (ent_rd.re),
      .raddr (ent_rd.addr),
      .rdata (ent_rdata)
   );

   // sample windows, a ring of WINDOW slots per entry
   sra_ram #(
      .WIDTH (16),
      .DEPTH (WIN_DEPTH)
   ) u_win_ram (
      .clock (clock),
      .we    (win_wr.we),
      .waddr (win_wr.addr),
      .wdata (win_wr.data),
      .re    (win_rd.re),
      .raddr (win_rd.addr),
      .rdata (win_rdata)
   );

endmodule

`default_nettype wire

// ===== src/sra_checker.sv =====
// ----------------------------------------------------------------------------
// sra_checker : port-level checks
// Watches the result channel of the table for consistent items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sra_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire sra_pkg::rsp_type rsp_data
);

   import sra_pkg::*;

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_UNKNOWN || rsp_data.status == ST_FULL)
      |-> rsp_data.room_of_sensor == NOT_FOUND_ROOM && rsp_data.average == '0
          && rsp_data.last_update == '0)
      else $error("miss item carries entry data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL
      |-> rsp_data.sensor_count == 7'(MAX_SENSORS))
      else $error("table full reported below capacity");

   a_fresh_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_REGISTERED
      |-> rsp_data.average == '0 && rsp_data.last_update == '0
          && rsp_data.sensor_count != '0)
      else $error("fresh entry not clear");

endmodule

bind sensor_running_average_table sra_checker u_sra_checker (.*);

`default_nettype wire
